// ----- design/fmpa_pkg.sv -----
package fmpa_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int OUT_BITS_DEF        = 16;

  localparam int SENS_BITS    = 32;
  localparam int INC_SHIFT    = 15;
  localparam int TAYLOR_TERMS = 10;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

  // (2n)(2n+1) for the odd Taylor terms of sine
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef enum logic [1:0] {
    QUAD_RISE     = 2'd0,
    QUAD_FALL     = 2'd1,
    QUAD_NEG_RISE = 2'd2,
    QUAD_NEG_FALL = 2'd3
  } quad_t;

  // Rounded, scaled sine of k * (pi/2) / 2^(addr_bits-2); evaluated at elaboration.
  function automatic logic [63:0] quarter_sine(input int unsigned k,
                                               input int unsigned addr_bits,
                                               input int unsigned out_bits);
    logic [63:0]        kk;
    logic [63:0]        quarter;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        amp;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    quarter = 64'd1 << (addr_bits - 2);
    kk      = 64'(k);
    if (kk > quarter) kk = quarter;
    x    = (kk * HALF_PI_Q30) >> (addr_bits - 2);
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = 64'sd0;
    amp  = (64'd1 << (out_bits - 1)) - 64'd1;
    prod = $unsigned(sum) * amp + Q30_HALF;
    sum  = $signed(prod >> 30);
    if (sum > $signed(amp)) sum = $signed(amp);
    return $unsigned(sum);
  endfunction

endpackage

// ----- design/fm_modulator_phase_accumulator.sv -----
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  in_sample_in (signed sample)
// result    out        out_valid/out_stall out_i_out, out_q_out (cos, sin)
// config    in         cfg_wr_en          cfg_wr_data (sensitivity)
//
// One sample per clock sustained while out_stall is low; a transfer passes prod_r, phase_r, then the result register.
// Stages: sample x sensitivity multiply, phase accumulate, sine/cosine table.
// A stalled result holds its stage; stall ripples back to in_stall in the same cycle.
// Synchronous reset clears the stage valids, the phase and the sensitivity.
module fm_modulator_phase_accumulator #(
  parameter int SAMPLE_BITS     = fmpa_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS      = fmpa_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = fmpa_pkg::TABLE_ADDR_BITS_DEF,
  parameter int OUT_BITS        = fmpa_pkg::OUT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic signed [fmpa_pkg::SENS_BITS-1:0] cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [OUT_BITS-1:0]          out_i_out,
  output logic signed [OUT_BITS-1:0]          out_q_out
);
  import fmpa_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + SENS_BITS;

  logic signed [SENS_BITS-1:0]  sens_r;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic [PHASE_BITS-1:0]        phase_r, phase_nxt;
  logic signed [OUT_BITS-1:0]   out_i_r, out_q_r;
  logic                         v1_r, v1_nxt;
  logic                         v2_r, v2_nxt;
  logic                         v3_r, v3_nxt;
  logic                         ready1, ready2, ready3;
  logic                         ld1, ld2, ld3;
  logic signed [PROD_BITS-1:0]  prod_shr;
  logic [PHASE_BITS-1:0]        inc;
  logic signed [OUT_BITS-1:0]   sin_val, cos_val;

  always_comb begin
    ready3 = !v3_r || !out_stall;
    ready2 = !v2_r || ready3;
    ready1 = !v1_r || ready2;
    ld1    = in_valid && ready1;
    ld2    = v1_r && ready2;
    ld3    = v2_r && ready3;
    v1_nxt = ready1 ? in_valid : v1_r;
    v2_nxt = ready2 ? v1_r : v2_r;
    v3_nxt = ready3 ? v2_r : v3_r;
  end

  // floor shift, then sign-extend or wrap to the phase width
  always_comb begin
    prod_shr  = prod_r >>> INC_SHIFT;
    inc       = PHASE_BITS'(prod_shr);
    phase_nxt = phase_r + inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= '0;
      phase_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) sens_r <= cfg_wr_data;
      if (ld2) phase_r <= phase_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) prod_r <= PROD_BITS'(in_sample_in) * PROD_BITS'(sens_r);
    if (ld3) begin
      out_i_r <= cos_val;
      out_q_r <= sin_val;
    end
  end

  fmpa_sincos_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .OUT_BITS        (OUT_BITS)
  ) u_rom (
    .addr    (phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  assign in_stall  = !ready1;
  assign out_valid = v3_r;
  assign out_i_out = out_i_r;
  assign out_q_out = out_q_r;

endmodule

// ----- design/fmpa_sincos_rom.sv -----
module fmpa_sincos_rom #(
  parameter int TABLE_ADDR_BITS = fmpa_pkg::TABLE_ADDR_BITS_DEF,
  parameter int OUT_BITS        = fmpa_pkg::OUT_BITS_DEF
) (
  input  logic [TABLE_ADDR_BITS-1:0] addr,
  output logic signed [OUT_BITS-1:0] sin_val,
  output logic signed [OUT_BITS-1:0] cos_val
);
  import fmpa_pkg::*;

  localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam logic [TABLE_ADDR_BITS-1:0] QTR_ADDR =
    TABLE_ADDR_BITS'(1) << (TABLE_ADDR_BITS - 2);
  localparam logic [OUT_BITS-2:0] PEAK =
    (OUT_BITS-1)'(quarter_sine(QUARTER, TABLE_ADDR_BITS, OUT_BITS));

  // first quarter wave, magnitudes only
  logic [OUT_BITS-2:0] qtab [QUARTER];

  for (genvar k = 0; k < QUARTER; k++) begin : g_qtab
    assign qtab[k] = (OUT_BITS-1)'(quarter_sine(k, TABLE_ADDR_BITS, OUT_BITS));
  end

  logic [TABLE_ADDR_BITS-1:0] lane_addr [2];
  logic signed [OUT_BITS-1:0] lane_val  [2];

  assign lane_addr[0] = addr;
  assign lane_addr[1] = addr + QTR_ADDR;  // cosine leads by a quarter turn

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-3:0] r;
    logic [TABLE_ADDR_BITS-3:0] r_mirror;
    logic [OUT_BITS-2:0]        mag_fwd;
    logic [OUT_BITS-2:0]        mag_rev;
    logic signed [OUT_BITS-1:0] pos;

    always_comb begin
      quad     = lane_addr[g][TABLE_ADDR_BITS-1:TABLE_ADDR_BITS-2];
      r        = lane_addr[g][TABLE_ADDR_BITS-3:0];
      r_mirror = '0 - r;  // QUARTER - r for nonzero r
      mag_fwd  = qtab[r];
      mag_rev  = (r == '0) ? PEAK : qtab[r_mirror];
      case (quad_t'(quad))
        QUAD_RISE:     pos = $signed({1'b0, mag_fwd});
        QUAD_FALL:     pos = $signed({1'b0, mag_rev});
        QUAD_NEG_RISE: pos = -$signed({1'b0, mag_fwd});
        QUAD_NEG_FALL: pos = -$signed({1'b0, mag_rev});
        default:       pos = $signed({1'b0, mag_fwd});
      endcase
      lane_val[g] = pos;
    end
  end

  assign sin_val = lane_val[0];
  assign cos_val = lane_val[1];

endmodule

// ----- design/fmpa_checker.sv -----
module fmpa_checker #(
  parameter int OUT_BITS    = fmpa_pkg::OUT_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [OUT_BITS-1:0]        out_i_out,
  input logic [OUT_BITS-1:0]        out_q_out
);
  import fmpa_pkg::*;

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // pipeline comes up empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_i_out) && $stable(out_q_out))
    else $error("stalled result changed");

  // table is symmetric; the most negative code never appears
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_i_out != MOST_NEG) && (out_q_out != MOST_NEG))
    else $error("most negative output code");

  // with no back-pressure a transfer passes the product, phase and result registers to out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after input transfer");

  // nothing in flight means no stall toward the source
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!in_valid) && $past(!in_valid, 2) && $past(!in_valid, 3)
      && $past(rst_n, 3) |-> !in_stall)
    else $error("input stalled while pipeline empty");

endmodule

bind fm_modulator_phase_accumulator fmpa_checker #(
  .OUT_BITS    (OUT_BITS)
) u_fmpa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_i_out    (out_i_out),
  .out_q_out    (out_q_out)
);

// ----- bench/fm_modulator_phase_accumulator_tb.sv -----
`timescale 1ns / 1ps

module fm_modulator_phase_accumulator_tb;

  localparam int SW    = fmpa_pkg::SAMPLE_BITS_DEF;
  localparam int PW    = fmpa_pkg::PHASE_BITS_DEF;
  localparam int AW    = fmpa_pkg::TABLE_ADDR_BITS_DEF;
  localparam int OW    = fmpa_pkg::OUT_BITS_DEF;
  localparam int KW    = fmpa_pkg::SENS_BITS;
  localparam int QTR   = 1 << (AW - 2);
  localparam int DEPTH = 1 << AW;
  localparam int PIPE_LATENCY = 3;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [KW-1:0] SENS_MAX   = {1'b0, {(KW-1){1'b1}}};
  localparam logic signed [KW-1:0] SENS_MIN   = {1'b1, {(KW-1){1'b0}}};

  typedef struct packed {
    logic signed [OW-1:0] cos_v;
    logic signed [OW-1:0] sin_v;
  } iq_pair_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_wr_en    = 1'b0;
  logic signed [KW-1:0] cfg_wr_data  = '0;
  logic                 in_valid     = 1'b0;
  logic signed [SW-1:0] in_sample_in = '0;
  logic                 out_stall    = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [OW-1:0] out_i_out;
  logic signed [OW-1:0] out_q_out;

  iq_pair_t             expected_iq[$];
  logic [PW-1:0]        phase_model = '0;
  logic signed [KW-1:0] sens_model  = '0;
  logic signed [OW-1:0] sine_rom [DEPTH];

  int errors        = 0;
  int samples_sent  = 0;
  int pairs_checked = 0;
  int sens_writes   = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;

  fm_modulator_phase_accumulator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i_out    (out_i_out),
    .out_q_out    (out_q_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Scaled sine of k quarter-table steps; Q30 odd-power series, each term truncated.
  function automatic longint quarter_wave(int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    longint      acc;
    longint      scaled;
    x   = (64'(k) * QUARTER_TURN_Q30) >> (AW - 2);
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= fmpa_pkg::TAYLOR_TERMS; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else            acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    scaled = (acc * ((longint'(1) << (OW - 1)) - 1) + (longint'(1) << 29)) >>> 30;
    if (scaled > (longint'(1) << (OW - 1)) - 1) scaled = (longint'(1) << (OW - 1)) - 1;
    return scaled;
  endfunction

  function automatic void build_sine_rom();
    longint qw [QTR + 1];
    int     r;
    for (int k = 0; k <= QTR; k++) qw[k] = quarter_wave(k);
    for (int a = 0; a < DEPTH; a++) begin
      r = a % QTR;
      case (fmpa_pkg::quad_t'(a / QTR))
        fmpa_pkg::QUAD_RISE:     sine_rom[a] = OW'(qw[r]);
        fmpa_pkg::QUAD_FALL:     sine_rom[a] = OW'(qw[QTR - r]);
        fmpa_pkg::QUAD_NEG_RISE: sine_rom[a] = OW'(-qw[r]);
        fmpa_pkg::QUAD_NEG_FALL: sine_rom[a] = OW'(-qw[QTR - r]);
        default:                 sine_rom[a] = OW'(qw[r]);
      endcase
    end
  endfunction

  // Advance the phase by the floored product and look up cos/sin of the new phase.
  function automatic void predict_pair(input logic signed [SW-1:0] s);
    logic signed [SW+KW-1:0] prod;
    logic [AW-1:0]           addr;
    iq_pair_t                pair;
    prod        = s * sens_model;
    phase_model = phase_model + PW'(prod >>> fmpa_pkg::INC_SHIFT);
    addr        = phase_model[PW-1 -: AW];
    pair.sin_v  = sine_rom[addr];
    pair.cos_v  = sine_rom[AW'(addr + QTR)];
    expected_iq.push_back(pair);
  endfunction

  function automatic logic signed [KW-1:0] random_sens();
    logic signed [KW-1:0] v;
    case ($urandom_range(5))
      0:       v = SENS_MAX;
      1:       v = SENS_MIN;
      2:       v = '0;
      3:       v = KW'($signed($urandom_range(65535)) - 32768);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(15))
      0:       v = SAMPLE_MAX;
      1:       v = SAMPLE_MIN;
      2:       v = SW'(-1);
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  // Leaves in_valid high when no gap follows; the caller sends again or drains.
  task automatic send_sample(input logic signed [SW-1:0] s);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pair(s);
    samples_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_iq.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_sensitivity(input logic signed [KW-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sens_model = v;
    sens_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // Sensitivity is zero out of reset, so the phase must stay at zero.
  task automatic test_reset_state();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
  endtask

  // Exact quarter and half turns land on the peaks of both tables.
  task automatic test_quadrant_steps();
    write_sensitivity(SENS_MIN);
    repeat (4) send_sample(SW'(-16384));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_large_increments();
    write_sensitivity(SENS_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SW'(-1));
    send_sample(SW'(1));
    send_sample(SW'(0));
  endtask

  // Steps below one table address, and a negative step that floors below zero.
  task automatic test_phase_truncation();
    write_sensitivity(1);
    send_sample(SW'(1));
    send_sample(SW'(-1));
    send_sample(SW'(-1));
    write_sensitivity(32'sd4194304);
    repeat (3) send_sample(SAMPLE_MAX);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    idle_pct  = idle;
    stall_pct = stall;
    for (int seg = 0; seg < 3; seg++) begin
      write_sensitivity(random_sens());
      for (int i = 0; i < count / 3; i++) begin
        send_sample(random_sample());
        // hold off now and then until the pipeline is empty
        if ($urandom_range(39) == 0) wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    iq_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_iq.size() == 0) begin
        $error("result transfer with nothing pending: i_out %0d, q_out %0d",
               out_i_out, out_q_out);
        errors++;
      end else begin
        want = expected_iq.pop_front();
        pairs_checked++;
        if (out_i_out !== want.cos_v) begin
          $error("i_out: expected %0d, got %0d", want.cos_v, out_i_out);
          errors++;
        end
        if (out_q_out !== want.sin_v) begin
          $error("q_out: expected %0d, got %0d", want.sin_v, out_q_out);
          errors++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  initial begin
    build_sine_rom();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_quadrant_steps();
    test_large_increments();
    test_phase_truncation();
    test_random_traffic(0, 0, 225);
    test_random_traffic(85, 0, 225);
    test_random_traffic(0, 85, 225);
    test_random_traffic(33, 33, 225);
    wait_drained();

    $display("Sent %0d samples, checked %0d I/Q pairs over %0d sensitivity settings,",
             samples_sent, pairs_checked, sens_writes);
    $display("with free-running, idle-sender, stalled-receiver and mixed handshakes.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
